// File: hw/rtl/ddw_pkg.sv
package ddw_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned DOY_W   = 9;
	localparam int unsigned DIFF_W  = 22;
	localparam int unsigned WD_W    = 3;

	// largest year accepted, larger years saturate here
	localparam logic [YEAR_W-1:0] YEAR_LIMIT = 14'd9999;
	// one 400-year cycle of shift, minus one for the days-before-year count
	localparam logic [YEAR_W-1:0] YEAR_OFFSET = 14'd399;

	// x / 25 = (x * REC25) >> REC25_SH, exact for x below 2600
	localparam int unsigned REC_W    = 23;
	localparam logic [11:0] REC25    = 12'd2622;
	localparam int unsigned REC25_SH = 16;

	// x / 7 = (x * REC7) >> REC7_SH, exact for x below 2**22
	localparam int unsigned PROD7_W = 45;
	localparam logic [22:0] REC7    = 23'd4793491;
	localparam int unsigned REC7_SH = 25;

	localparam logic [DIFF_W-1:0] DAYS_PER_YEAR = 22'd365;

	typedef struct packed {
		logic [YEAR_W-1:0]  year_a;
		logic [MONTH_W-1:0] month_a;
		logic [DAY_W-1:0]   day_a;
		logic [YEAR_W-1:0]  year_b;
		logic [MONTH_W-1:0] month_b;
		logic [DAY_W-1:0]   day_b;
	} dates_t;

	typedef struct packed {
		logic [DOY_W-1:0]  day_of_year_a;
		logic [DIFF_W-1:0] days_between;
		logic [WD_W-1:0]   weekday_a;
	} result_t;

	// one date after classification by the front end
	typedef struct packed {
		logic [YEAR_W-1:0] year;   // saturated year
		logic [DOY_W-1:0]  cum;    // days of the months before, common year
		logic              late;   // month past february
		logic [DAY_W-1:0]  day;
		logic              div4;   // year divisible by 4
		logic [REC_W-1:0]  rec;    // (year / 4) * REC25
	} date_cls_t;

	typedef struct packed {
		date_cls_t a;
		date_cls_t b;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} queue_head_t;

endpackage

// File: hw/rtl/ddw_front.sv
module ddw_front (
	input  logic            start,
	input  logic            full,
	input  ddw_pkg::dates_t dates,
	output logic            busy,
	output logic            push,
	output ddw_pkg::entry_t entry
);
	import ddw_pkg::*;

	function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
		logic [DOY_W-1:0] c;
		case (month) inside
			4'd0, 4'd1: c = 9'd0;
			4'd2:       c = 9'd31;
			4'd3:       c = 9'd59;
			4'd4:       c = 9'd90;
			4'd5:       c = 9'd120;
			4'd6:       c = 9'd151;
			4'd7:       c = 9'd181;
			4'd8:       c = 9'd212;
			4'd9:       c = 9'd243;
			4'd10:      c = 9'd273;
			4'd11:      c = 9'd304;
			default:    c = 9'd334;
		endcase
		return c;
	endfunction

	function automatic date_cls_t classify(input logic [YEAR_W-1:0] year,
			input logic [MONTH_W-1:0] month, input logic [DAY_W-1:0] day);
		logic [YEAR_W-1:0] y;
		date_cls_t         c;
		y      = (year > YEAR_LIMIT) ? YEAR_LIMIT : year;
		c.year = y;
		c.cum  = cum_days(month);
		c.late = (month >= 4'd3);
		c.day  = day;
		c.div4 = (y[1:0] == 2'b00);
		c.rec  = REC_W'(y[YEAR_W-1:2]) * REC_W'(REC25);
		return c;
	endfunction

	assign busy    = full;
	assign push    = start && !full;
	assign entry.a = classify(dates.year_a, dates.month_a, dates.day_a);
	assign entry.b = classify(dates.year_b, dates.month_b, dates.day_b);

endmodule

// File: hw/rtl/ddw_queue.sv
module ddw_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ddw_pkg::entry_t      entry,
	input  logic                 pop,
	output logic                 full,
	output ddw_pkg::queue_head_t head
);
	import ddw_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               empty;
	logic               do_push;
	logic               do_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	assign head.valid = !empty;
	assign head.entry = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= next_ptr(wr_q);
			if (do_pop)  rd_q <= next_ptr(rd_q);
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= entry;
	end

endmodule

// File: hw/rtl/ddw_back.sv
module ddw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ddw_pkg::queue_head_t head,
	output logic                 pop,
	output logic                 done,
	output ddw_pkg::result_t     result
);
	import ddw_pkg::*;

	// ordinal day, with the leap check finished from the front's reciprocal product
	function automatic logic [DOY_W-1:0] ordinal(input date_cls_t c);
		logic [6:0]  d;
		logic [11:0] t;
		logic        h;
		logic        f;
		logic        leap;
		d    = c.rec[REC_W-1:REC25_SH];
		t    = c.year[YEAR_W-1:2];
		h    = c.div4 && (t == 12'(d) * 12'd25);
		f    = h && (d[1:0] == 2'b00);
		leap = c.div4 && (!h || f);
		return c.cum + DOY_W'(c.day) + DOY_W'(c.late && leap);
	endfunction

	function automatic logic [DIFF_W-1:0] day_count(input logic [YEAR_W-1:0] p,
			input logic [11:0] q4, input logic [REC_W-1:0] rec, input logic [DOY_W-1:0] doy);
		logic [6:0] c;
		c = rec[REC_W-1:REC25_SH];
		return DIFF_W'(p) * DAYS_PER_YEAR + DIFF_W'(q4) - DIFF_W'(c)
			+ DIFF_W'(c[6:2]) + DIFF_W'(doy);
	endfunction

	logic [YEAR_W-1:0] p_a;
	logic [YEAR_W-1:0] p_b;

	logic              v_s1;
	logic [DOY_W-1:0]  doy_a_s1;
	logic [DOY_W-1:0]  doy_b_s1;
	logic [YEAR_W-1:0] p_a_s1;
	logic [YEAR_W-1:0] p_b_s1;
	logic [REC_W-1:0]  rec_a_s1;
	logic [REC_W-1:0]  rec_b_s1;

	logic              v_s2;
	logic [DOY_W-1:0]  doy_a_s2;
	logic [DIFF_W-1:0] na_s2;
	logic [DIFF_W-1:0] nb_s2;

	logic              v_s3;
	logic [DOY_W-1:0]  doy_a_s3;
	logic [DIFF_W-1:0] diff_s3;
	logic [2:0]        x_lo_s3;
	logic [2:0]        q_lo_s3;

	logic [DIFF_W-1:0]  x;
	logic [PROD7_W-1:0] prod7;

	logic    done_q;
	result_t result_q;

	assign pop = head.valid;
	assign p_a = head.entry.a.year + YEAR_OFFSET;
	assign p_b = head.entry.b.year + YEAR_OFFSET;

	assign x     = na_s2 - 1'b1;
	assign prod7 = PROD7_W'(x) * PROD7_W'(REC7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= head.valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		doy_a_s1 <= ordinal(head.entry.a);
		doy_b_s1 <= ordinal(head.entry.b);
		p_a_s1   <= p_a;
		p_b_s1   <= p_b;
		rec_a_s1 <= REC_W'(p_a[YEAR_W-1:2]) * REC_W'(REC25);
		rec_b_s1 <= REC_W'(p_b[YEAR_W-1:2]) * REC_W'(REC25);

		doy_a_s2 <= doy_a_s1;
		na_s2    <= day_count(p_a_s1, p_a_s1[YEAR_W-1:2], rec_a_s1, doy_a_s1);
		nb_s2    <= day_count(p_b_s1, p_b_s1[YEAR_W-1:2], rec_b_s1, doy_b_s1);

		doy_a_s3 <= doy_a_s2;
		diff_s3  <= (na_s2 >= nb_s2) ? (na_s2 - nb_s2) : (nb_s2 - na_s2);
		x_lo_s3  <= x[2:0];
		q_lo_s3  <= prod7[REC7_SH+2:REC7_SH];

		// x mod 7 = x - 7q, and -7q is q modulo 8
		result_q.day_of_year_a <= doy_a_s3;
		result_q.days_between  <= diff_s3;
		result_q.weekday_a     <= x_lo_s3 + q_lo_s3 + 3'd1;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: hw/rtl/date_difference_and_weekday_unit.sv
// Takes a pair of dates on each start transfer and returns day of year of date A, the
// absolute day distance between A and B, and the weekday of A (1 Monday to 7 Sunday).
// One item can be accepted every clock cycle while busy is low; its result shows on done
// and result for one cycle and is taken once it has passed one queue slot and then a
// four-stage back end. The receiver cannot hold results off and the back end never
// stalls, so with QUEUE_DEPTH above 1 the queue does not fill and busy stays low in
// operation. Years above 9999 saturate, month 0 reads as January, months above 12 read
// as December, and days are not checked.
module date_difference_and_weekday_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ddw_pkg::dates_t  dates,
	output logic             done,
	output ddw_pkg::result_t result
);
	import ddw_pkg::*;

	logic        full;
	logic        push;
	logic        pop;
	entry_t      entry;
	queue_head_t head;

	ddw_front u_front (
		.start (start),
		.full  (full),
		.dates (dates),
		.busy  (busy),
		.push  (push),
		.entry (entry)
	);

	ddw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (entry),
		.pop    (pop),
		.full   (full),
		.head   (head)
	);

	ddw_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

// File: hw/rtl/ddw_checker.sv
module ddw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input ddw_pkg::dates_t  dates,
	input logic             done,
	input ddw_pkg::result_t result
);
	import ddw_pkg::*;

	// every transfer comes out after fixed latency
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##5 done)
		else $error("transfer without result");

	// no result without a transfer
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result without transfer");

	// equal dates give zero distance
	a_same_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && dates.year_a == dates.year_b && dates.month_a == dates.month_b
			&& dates.day_a == dates.day_b |-> ##5 result.days_between == '0)
		else $error("nonzero distance for equal dates");

	// back-to-back identical items give identical results
	a_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && $past(dates, 5) == $past(dates, 6) |-> $stable(result))
		else $error("repeated item changed result");

	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.weekday_a != '0)
		else $error("weekday zero");

endmodule

bind date_difference_and_weekday_unit ddw_checker u_ddw_checker (.*);
